[rtl/core/msg_pkg.sv]
// shared types and constants of the motion setpoint generator
package msg_pkg;

  // command codes carried on s_tuser
  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_TURN   = 2'd2
  } op_t;

  // sensor group codes
  localparam logic [1:0] SENS_FRONT = 2'd0;
  localparam logic [1:0] SENS_BACK  = 2'd1;
  localparam logic [1:0] SENS_ALL   = 2'd2;

  // field widths
  localparam int DIST_W  = 13;
  localparam int ANG_W   = 14;
  localparam int SPDIN_W = 8;
  localparam int SPD_W   = 7;
  localparam int POS_W   = 20;
  localparam int HEAD_W  = 16;

  // internal widths
  localparam int XW     = 36;  // cordic vector, 1/16 mm with 16 fraction bits
  localparam int ZW     = 32;  // cordic angle, radians q28
  localparam int GAIN_W = 44;  // distance times gain
  localparam int DEG_W  = 36;  // angle times degree factor
  localparam int RAD_W  = 18;  // converted angle and heading sum

  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 64;
  localparam int IN_USER_W   = 2;
  localparam int OUT_USER_W  = 3;
  localparam int ATAN_LEN    = 24;

  localparam logic signed [ZW-1:0]     PI_Q28      = 32'sd843314857;
  localparam logic signed [ZW-1:0]     TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [ZW-1:0]     HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [GAIN_W-1:0] GAIN_Q30    = 44'sd652032874;
  localparam logic signed [DEG_W-1:0]  DEG_TO_RAD  = 36'sd292818;

  localparam logic [SPDIN_W-1:0] SPEED_MAX = 8'd100;
  localparam logic [SPDIN_W-1:0] SPEED_MIN = 8'd1;

  // command fields that ride along the pipeline
  typedef struct packed {
    op_t                      op;
    logic [SPD_W-1:0]         speed;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [HEAD_W-1:0] th;
    logic                     dneg;
    logic                     hsat;
  } carry_t;

  // arctangent of 2^-i in radians q28
  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097109;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/motion_setpoint_generator.sv]
// motion setpoint generator: pipelined cordic move, heading rotate and turn
//
// usage:
//   s_* carries one command per transfer: s_tuser holds the opcode (move,
//   rotate relative, turn absolute), s_tdata the distance, angle, speed
//   request and the current pose. m_* returns exactly one setpoint per
//   command in the same order: m_tdata holds speed and target pose,
//   m_tuser the sensor group and the saturation flag.
// pipeline: the command passes CORDIC_STAGES + 4 registers (multiply stage,
//   fold stage, one stage per cordic rotation, rounding stage, output
//   register), the first of them loaded at the transfer edge itself
// throughput: one command per cycle while m_tready is high; the unrolled
//   cordic rotation chain holds one command in each stage.
// stall: every stage has its own valid bit and loads when it is empty or
//   its successor moves, so bubbles close up and s_tready stays high while
//   a result waits on m_tready as long as any stage is free. nothing is
//   dropped or repeated.
// reset: rst clears all valid bits; the pipeline comes up empty and ready.
module motion_setpoint_generator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // distance_mm, angle_sixteenth_deg, speed_request, pose_x, pose_y,
  // pose_heading (lowest first), zero padded
  input  logic [msg_pkg::IN_DATA_W-1:0]      s_tdata,
  // opcode
  input  logic [msg_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // speed_percent, target_x, target_y, target_heading (lowest first),
  // zero padded
  output logic [msg_pkg::OUT_DATA_W-1:0]     m_tdata,
  // sensor_group, saturated
  output logic [msg_pkg::OUT_USER_W-1:0]     m_tuser
);
  import msg_pkg::*;

  localparam int N = CORDIC_STAGES;

  // input field unpacking
  logic signed [DIST_W-1:0]  in_dist;
  logic signed [ANG_W-1:0]   in_ang;
  logic [SPDIN_W-1:0]        in_spd;
  logic signed [POS_W-1:0]   in_px;
  logic signed [POS_W-1:0]   in_py;
  logic signed [HEAD_W-1:0]  in_ph;

  assign in_dist = s_tdata[12:0];
  assign in_ang  = s_tdata[26:13];
  assign in_spd  = s_tdata[34:27];
  assign in_px   = s_tdata[54:35];
  assign in_py   = s_tdata[74:55];
  assign in_ph   = s_tdata[90:75];

  // stage enables, from the output back to the input
  logic         en_o;
  logic         en_f;
  logic         en_a;
  logic [N:0]   c_en;

  // stage a: products, heading range reduction, speed clamp
  logic                      a_valid;
  carry_t                    a_carry;
  logic signed [GAIN_W-1:0]  a_gain;
  logic signed [DEG_W-1:0]   a_deg;
  logic signed [ZW-1:0]      a_z;

  // cordic chain, index 0 is the fold stage output
  logic                      c_valid [0:N];
  carry_t                    c_carry [0:N];
  logic signed [XW-1:0]      c_x     [0:N];
  logic signed [XW-1:0]      c_y     [0:N];
  logic signed [ZW-1:0]      c_z     [0:N];

  // stage f: rounded offsets
  logic                      f_valid;
  carry_t                    f_carry;
  logic signed [POS_W-1:0]   f_dx;
  logic signed [POS_W-1:0]   f_dy;

  assign en_o     = !m_tvalid || m_tready;
  assign en_f     = !f_valid || en_o;
  assign c_en[N]  = !c_valid[N] || en_f;
  assign en_a     = !a_valid || c_en[0];
  assign s_tready = en_a;

  // ---------------------------------------------------------------- stage a
  logic signed [ZW-1:0]  z_raw;
  logic signed [ZW-1:0]  z_red;
  logic [SPD_W-1:0]      spd_clamped;
  carry_t                a_carry_next;

  always_comb begin
    z_raw = {in_ph, 16'b0};
    // one turn of 2*pi always brings a q4.12 heading into [-pi, pi]
    if (z_raw > PI_Q28) begin
      z_red = z_raw - TWO_PI_Q28;
    end else if (z_raw < -PI_Q28) begin
      z_red = z_raw + TWO_PI_Q28;
    end else begin
      z_red = z_raw;
    end
    if (in_spd > SPEED_MAX) begin
      spd_clamped = SPD_W'(SPEED_MAX);
    end else if (in_spd < SPEED_MIN) begin
      spd_clamped = SPD_W'(SPEED_MIN);
    end else begin
      spd_clamped = in_spd[SPD_W-1:0];
    end
    a_carry_next.op    = op_t'(s_tuser);
    a_carry_next.speed = spd_clamped;
    a_carry_next.px    = in_px;
    a_carry_next.py    = in_py;
    a_carry_next.th    = in_ph;
    a_carry_next.dneg  = in_dist[DIST_W-1];
    a_carry_next.hsat  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_carry <= a_carry_next;
      a_gain  <= GAIN_W'(in_dist) * GAIN_Q30;
      a_deg   <= DEG_W'(in_ang) * DEG_TO_RAD;
      a_z     <= z_red;
    end
  end

  // ------------------------------------------------------------- fold stage
  logic signed [GAIN_W-1:0]   gain_rnd;
  logic signed [XW-1:0]       x_start;
  logic signed [ZW-1:0]       z_fold;
  logic signed [XW-1:0]       x_fold;
  logic signed [DEG_W-1:0]    deg_rnd;
  logic signed [RAD_W-1:0]    rad;
  logic signed [RAD_W-1:0]    head_sum;
  carry_t                     b_carry_next;

  always_comb begin
    gain_rnd = (a_gain + GAIN_W'(512)) >>> 10;
    x_start  = XW'(gain_rnd);
    // outside +-pi/2 turn by pi and flip the start vector
    if (a_z > HALF_PI_Q28) begin
      z_fold = a_z - PI_Q28;
      x_fold = -x_start;
    end else if (a_z < -HALF_PI_Q28) begin
      z_fold = a_z + PI_Q28;
      x_fold = -x_start;
    end else begin
      z_fold = a_z;
      x_fold = x_start;
    end

    deg_rnd = (a_deg + DEG_W'(32768)) >>> 16;
    rad     = RAD_W'(deg_rnd);
    if (a_carry.op == OP_ROTATE) begin
      head_sum = RAD_W'(a_carry.th) + rad;
    end else begin
      head_sum = rad;
    end

    b_carry_next = a_carry;
    if (a_carry.op == OP_ROTATE || a_carry.op == OP_TURN) begin
      if (head_sum > RAD_W'(32767)) begin
        b_carry_next.th   = 16'sh7fff;
        b_carry_next.hsat = 1'b1;
      end else if (head_sum < -RAD_W'(32768)) begin
        b_carry_next.th   = -16'sh8000;
        b_carry_next.hsat = 1'b1;
      end else begin
        b_carry_next.th   = HEAD_W'(head_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (c_en[0]) begin
      c_valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en[0]) begin
      c_carry[0] <= b_carry_next;
      c_x[0]     <= x_fold;
      c_y[0]     <= '0;
      c_z[0]     <= z_fold;
    end
  end

  // ------------------------------------------------------ cordic rotations
  for (genvar i = 1; i <= N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = atan_q28(5'(i - 1));
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign c_en[i-1] = !c_valid[i-1] || c_en[i];
    assign xs = c_x[i-1] >>> (i - 1);
    assign ys = c_y[i-1] >>> (i - 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[i] <= 1'b0;
      end else if (c_en[i]) begin
        c_valid[i] <= c_valid[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (c_en[i]) begin
        c_carry[i] <= c_carry[i-1];
        if (c_z[i-1] >= 0) begin
          c_x[i] <= c_x[i-1] - ys;
          c_y[i] <= c_y[i-1] + xs;
          c_z[i] <= c_z[i-1] - ATAN;
        end else begin
          c_x[i] <= c_x[i-1] + ys;
          c_y[i] <= c_y[i-1] - xs;
          c_z[i] <= c_z[i-1] + ATAN;
        end
      end
    end
  end

  // ---------------------------------------------------------- rounding stage
  logic signed [XW-1:0] x_rnd;
  logic signed [XW-1:0] y_rnd;

  assign x_rnd = (c_x[N] + XW'(32768)) >>> 16;
  assign y_rnd = (c_y[N] + XW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en_f) begin
      f_valid <= c_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_carry <= c_carry[N];
      f_dx    <= POS_W'(x_rnd);
      f_dy    <= POS_W'(y_rnd);
    end
  end

  // -------------------------------------------------------- output register
  logic signed [POS_W:0]    sum_x;
  logic signed [POS_W:0]    sum_y;
  logic signed [POS_W-1:0]  tx;
  logic signed [POS_W-1:0]  ty;
  logic                     xsat;
  logic                     ysat;
  logic [1:0]               sensors;
  logic                     sat;
  logic [OUT_DATA_W-1:0]    out_data_next;
  logic [OUT_USER_W-1:0]    out_user_next;

  localparam logic signed [POS_W:0] POS_HI = 21'sd524287;
  localparam logic signed [POS_W:0] POS_LO = -21'sd524288;

  always_comb begin
    sum_x = (POS_W+1)'(f_carry.px) + (POS_W+1)'(f_dx);
    sum_y = (POS_W+1)'(f_carry.py) + (POS_W+1)'(f_dy);
    tx    = f_carry.px;
    ty    = f_carry.py;
    xsat  = 1'b0;
    ysat  = 1'b0;
    if (f_carry.op == OP_MOVE) begin
      if (sum_x > POS_HI) begin
        tx = POS_W'(POS_HI); xsat = 1'b1;
      end else if (sum_x < POS_LO) begin
        tx = POS_W'(POS_LO); xsat = 1'b1;
      end else begin
        tx = POS_W'(sum_x);
      end
      if (sum_y > POS_HI) begin
        ty = POS_W'(POS_HI); ysat = 1'b1;
      end else if (sum_y < POS_LO) begin
        ty = POS_W'(POS_LO); ysat = 1'b1;
      end else begin
        ty = POS_W'(sum_y);
      end
      sensors = f_carry.dneg ? SENS_BACK : SENS_FRONT;
      sat     = xsat || ysat;
    end else begin
      // heading commands and the unused code keep the position
      sensors = SENS_ALL;
      sat     = f_carry.hsat;
    end
    out_data_next = {1'b0, f_carry.th, ty, tx, f_carry.speed};
    out_user_next = {sat, sensors};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_o) begin
      m_tvalid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      m_tdata <= out_data_next;
      m_tuser <= out_user_next;
    end
  end

endmodule

[bench/tb_top.sv]
// self-checking bench for the motion setpoint generator: directed and random commands
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cordic depth of the instance, and the pipeline depth that follows from it
  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 4;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  // the opcode value the package leaves unnamed; the block holds the pose
  localparam logic [1:0] OP_HOLD = 2'd3;

  // fixed point constants of the setpoint math (radians q28, gain q30)
  localparam longint HALF_TURN = 64'sd843314857;
  localparam longint FULL_TURN = 64'sd1686629713;
  localparam longint QUARTER_TURN = 64'sd421657428;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint DEG16_SCALE = 64'sd292818;

  // arctangent of 2^-i, radians q28
  longint atan_step [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  typedef struct {
    logic [1:0]         opcode;
    logic signed [12:0] distance;
    logic signed [13:0] ang;
    logic [7:0]         spd;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [15:0] ph;
  } command_t;

  typedef struct {
    logic [6:0]         speed;
    logic signed [19:0] tx;
    logic signed [19:0] ty;
    logic signed [15:0] th;
    logic [1:0]         sensors;
    logic               sat;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // distance_mm, angle_sixteenth_deg, speed_request, pose_x, pose_y,
  // pose_heading (lowest first), zero padded
  logic [msg_pkg::IN_DATA_W-1:0] s_tdata = '0;
  // opcode
  logic [msg_pkg::IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // speed_percent, target_x, target_y, target_heading (lowest first), zero padded
  logic [msg_pkg::OUT_DATA_W-1:0] m_tdata;
  // sensor_group, saturated
  logic [msg_pkg::OUT_USER_W-1:0] m_tuser;

  // setpoints predicted for accepted commands, oldest first
  setpoint_t pending_setpoints [$];
  int error_count = 0;
  // percent of cycles in which each side holds back
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  motion_setpoint_generator #(
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // saturate to a field range and note the clipping
  function automatic longint clamp_field(input longint v, input longint lo, input longint hi,
                                         inout bit clipped);
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // 1/16 degree to radians q12, rounded half up
  function automatic longint deg16_to_q12(input longint a);
    return (a * DEG16_SCALE + 32768) >>> 16;
  endfunction

  // expected setpoint of one command; the block holds no state between commands
  function automatic setpoint_t predict_setpoint(input command_t c);
    setpoint_t r;
    longint x, y, z, xs, ys;
    longint tx, ty, th;
    bit clipped;
    clipped = 1'b0;
    tx = c.px;
    ty = c.py;
    th = c.ph;
    r.sensors = msg_pkg::SENS_ALL;
    if (c.opcode == msg_pkg::OP_MOVE) begin
      // start vector pre-scaled by the cordic gain, 16 fraction bits
      z = longint'(c.ph) * 65536;
      x = (longint'(c.distance) * CORDIC_GAIN + 512) >>> 10;
      y = 0;
      // wrap into [-pi, pi], then fold the rear half plane by negating the vector
      while (z > HALF_TURN) z -= FULL_TURN;
      while (z < -HALF_TURN) z += FULL_TURN;
      if (z > QUARTER_TURN) begin
        z -= HALF_TURN;
        x = -x;
      end else if (z < -QUARTER_TURN) begin
        z += HALF_TURN;
        x = -x;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= atan_step[i];
        end else begin
          x += ys;
          y -= xs;
          z += atan_step[i];
        end
      end
      tx = clamp_field(longint'(c.px) + ((x + 32768) >>> 16), -524288, 524287, clipped);
      ty = clamp_field(longint'(c.py) + ((y + 32768) >>> 16), -524288, 524287, clipped);
      r.sensors = (c.distance >= 0) ? msg_pkg::SENS_FRONT : msg_pkg::SENS_BACK;
    end else if (c.opcode == msg_pkg::OP_ROTATE) begin
      th = clamp_field(longint'(c.ph) + deg16_to_q12(c.ang), -32768, 32767, clipped);
    end else if (c.opcode == msg_pkg::OP_TURN) begin
      th = clamp_field(deg16_to_q12(c.ang), -32768, 32767, clipped);
    end
    if (c.spd > 8'd100) r.speed = 7'd100;
    else if (c.spd < 8'd1) r.speed = 7'd1;
    else r.speed = c.spd[6:0];
    r.tx = tx[19:0];
    r.ty = ty[19:0];
    r.th = th[15:0];
    r.sat = clipped;
    return r;
  endfunction

  function automatic command_t make_command(input logic [1:0] op, input int distance,
                                            input int ang, input int spd, input int px,
                                            input int py, input int ph);
    command_t c;
    c.opcode = op;
    c.distance = 13'(distance);
    c.ang = 14'(ang);
    c.spd = 8'(spd);
    c.px = 20'(px);
    c.py = 20'(py);
    c.ph = 16'(ph);
    return c;
  endfunction

  // random value that lands on the range ends and near zero more often than by chance
  function automatic int pick_value(input int lo, input int hi);
    int v;
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      2: return lo + int'($urandom_range(3));
      3: return hi - int'($urandom_range(3));
      4: begin
        v = int'($urandom_range(64)) - 32;
        return (v < lo) ? lo : v;
      end
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  // one command transfer; s_tvalid stays high afterwards so back-to-back sends stream
  task automatic send_command(input command_t c);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, c.ph, c.py, c.px, c.spd, c.ang, c.distance};
    s_tuser <= c.opcode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_setpoints.push_back(predict_setpoint(c));
  endtask

  // stop sending, let every setpoint come back, then let the pipeline settle
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // straight moves: distance extremes, heading wrap and fold, position saturation
  task automatic test_move_directed();
    send_command(make_command(msg_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 255, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_MOVE, -4096, 0, 100, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 101, 1000, -1000, 32767));
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 1, -1000, 1000, -32768));
    // just inside and just beyond a quarter turn, both signs
    send_command(make_command(msg_pkg::OP_MOVE, 1000, 0, 50, 0, 0, 6433));
    send_command(make_command(msg_pkg::OP_MOVE, 1000, 0, 50, 0, 0, 6434));
    send_command(make_command(msg_pkg::OP_MOVE, -1000, 0, 50, 0, 0, -6433));
    send_command(make_command(msg_pkg::OP_MOVE, -1000, 0, 50, 0, 0, -6434));
    // target runs off each end of the position range
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 99, 524287, 0, 0));
    send_command(make_command(msg_pkg::OP_MOVE, -4096, 0, 2, -524288, 0, 0));
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 70, 0, 524287, 6433));
    send_command(make_command(msg_pkg::OP_MOVE, 4095, 0, 70, 0, -524288, -6433));
  endtask

  // rotate and turn: heading saturation and angles beyond one turn
  task automatic test_heading_directed();
    send_command(make_command(msg_pkg::OP_ROTATE, 0, 5760, 100, 12345, -54321, 32767));
    send_command(make_command(msg_pkg::OP_ROTATE, 0, -5760, 0, 0, 0, -32768));
    send_command(make_command(msg_pkg::OP_ROTATE, 0, -8192, 128, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_ROTATE, 0, 8191, 7, 0, 0, 100));
    send_command(make_command(msg_pkg::OP_TURN, 0, 5760, 100, -7, 7, 1234));
    send_command(make_command(msg_pkg::OP_TURN, 0, 8191, 255, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_TURN, 0, -8192, 1, 0, 0, 0));
    send_command(make_command(msg_pkg::OP_TURN, 0, 0, 40, 524287, -524288, -32768));
  endtask

  // the spare opcode holds the pose whatever the other fields say
  task automatic test_hold_directed();
    send_command(make_command(OP_HOLD, 4095, 8191, 255, 524287, -524288, 32767));
    send_command(make_command(OP_HOLD, -4096, -8192, 0, -524288, 524287, -32768));
  endtask

  // random commands with both sides idling at the given rates
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    command_t c;
    int sel;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      sel = $urandom_range(9);
      if (sel < 5) c.opcode = msg_pkg::OP_MOVE;
      else if (sel < 7) c.opcode = msg_pkg::OP_ROTATE;
      else if (sel < 9) c.opcode = msg_pkg::OP_TURN;
      else c.opcode = OP_HOLD;
      c.distance = 13'(pick_value(-4096, 4095));
      // mostly within one turn, sometimes the whole field
      if ($urandom_range(3) == 0) c.ang = 14'(pick_value(-8192, 8191));
      else c.ang = 14'(pick_value(-5760, 5760));
      c.spd = 8'(pick_value(0, 255));
      c.px = 20'(pick_value(-524288, 524287));
      c.py = 20'(pick_value(-524288, 524287));
      c.ph = 16'(pick_value(-32768, 32767));
      send_command(c);
    end
    drain_pipeline();
  endtask

  // receiver back-pressure, one decision per cycle
  always @(posedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // compare each setpoint transfer with the oldest prediction
  always @(posedge clk) begin
    setpoint_t want;
    setpoint_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.speed = m_tdata[6:0];
      got.tx = m_tdata[26:7];
      got.ty = m_tdata[46:27];
      got.th = m_tdata[62:47];
      got.sensors = m_tuser[1:0];
      got.sat = m_tuser[2];
      if (pending_setpoints.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%t: setpoint with none expected: tdata=%h tuser=%h", $realtime,
                   m_tdata, m_tuser);
      end else begin
        want = pending_setpoints.pop_front();
        if (got.speed !== want.speed || got.tx !== want.tx || got.ty !== want.ty ||
            got.th !== want.th || got.sensors !== want.sensors || got.sat !== want.sat) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%t: setpoint mismatch", $realtime);
            $display("  expected speed=%0d x=%0d y=%0d heading=%0d sensors=%0d sat=%0d",
                     want.speed, want.tx, want.ty, want.th, want.sensors, want.sat);
            $display("  actual   speed=%0d x=%0d y=%0d heading=%0d sensors=%0d sat=%0d",
                     got.speed, got.tx, got.ty, got.th, got.sensors, got.sat);
          end
        end
      end
    end
  end

  // hang detection: too long without any transfer on either side
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck = 0;
      else stuck++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_move_directed();
    test_heading_directed();
    test_hold_directed();
    drain_pipeline();
    // receiver slow first, then sender slow, then full rate
    test_random_traffic(420, 22, 78);
    test_random_traffic(420, 78, 22);
    test_random_traffic(410, 0, 0);
    if (error_count == 0 && pending_setpoints.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/msg_pkg.sv
rtl/core/motion_setpoint_generator.sv
bench/tb_top.sv
